[hw/rtl/mbr_pkg.sv]
package mbr_pkg;

  localparam int unsigned BUF_BYTES     = 16;
  localparam int unsigned MAX_READ_BITS = 32;

  localparam int unsigned BUF_AW   = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned CNT_W    = $clog2(BUF_BYTES + 1);
  localparam int unsigned UNREAD_W = $clog2(BUF_BYTES * 8 + 1);
  localparam int unsigned REM_W    = $clog2(MAX_READ_BITS + 1);
  localparam int unsigned VALUE_W  = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BADCOUNT  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_READ,
    CMD_BAD
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_TAKE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [5:0]  n;
  } cmd_t;

  function automatic logic [BUF_AW-1:0] next_idx(input logic [BUF_AW-1:0] idx);
    return (idx == BUF_AW'(BUF_BYTES - 1)) ? '0 : idx + BUF_AW'(1);
  endfunction

  function automatic logic [UNREAD_W-1:0] unread(input logic [CNT_W-1:0] cnt,
                                                 input logic [2:0] pos);
    return (UNREAD_W'(cnt) << 3) - UNREAD_W'(pos);
  endfunction

  function automatic logic [7:0] sat8(input logic [UNREAD_W-1:0] u);
    logic [7:0] r;
    if (u > UNREAD_W'(255) && UNREAD_W > 8) begin
      r = 8'hFF;
    end else begin
      r = u[7:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/mbr_in_if.sv]
interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;
  logic [5:0] n_bits;

  modport source (output valid, output op, output byte_in, output n_bits, input ready);
  modport sink (input valid, input op, input byte_in, input n_bits, output ready);
endinterface

[hw/rtl/mbr_out_if.sv]
interface mbr_out_if;
  logic                    valid;
  logic                    ready;
  logic [31:0]             value;
  mbr_pkg::status_t        status;
  logic [7:0]              bits_left;

  modport source (output valid, output value, output status, output bits_left, input ready);
  modport sink (input valid, input value, input status, input bits_left, output ready);
endinterface

[hw/rtl/mbr_cmd_if.sv]
interface mbr_cmd_if;
  logic          valid;
  logic          ready;
  mbr_pkg::cmd_t cmd;

  modport source (output valid, output cmd, input ready);
  modport sink (input valid, input cmd, output ready);
endinterface

[hw/rtl/mbr_front.sv]
module mbr_front (
  input logic         clk,
  input logic         rst,
  mbr_in_if.sink      req,
  mbr_cmd_if.source   cmd
);

  logic          hold_valid;
  mbr_pkg::cmd_t hold;
  mbr_pkg::cmd_t classified;
  logic          bad_count;

  always_comb begin
    bad_count       = (req.n_bits == 6'd0) || (req.n_bits > mbr_pkg::MAX_READ_BITS);
    classified.data = req.byte_in;
    classified.n    = req.n_bits;
    if (!req.op) begin
      classified.kind = mbr_pkg::CMD_PUSH;
    end else if (bad_count) begin
      classified.kind = mbr_pkg::CMD_BAD;
    end else begin
      classified.kind = mbr_pkg::CMD_READ;
    end
  end

  assign req.ready = !hold_valid || cmd.ready;
  assign cmd.valid = hold_valid;
  assign cmd.cmd   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req.ready) begin
      hold_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      hold <= classified;
    end
  end

endmodule

[hw/rtl/mbr_cmdq.sv]
module mbr_cmdq (
  input logic        clk,
  input logic        rst,
  mbr_cmd_if.sink    enq,
  mbr_cmd_if.source  deq
);

  mbr_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign enq.ready = (cnt != 2'd2);
  assign deq.valid = (cnt != 2'd0);
  assign deq.cmd   = slots[rd_ptr];
  assign push      = enq.valid && enq.ready;
  assign pop       = deq.valid && deq.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= enq.cmd;
    end
  end

endmodule

[hw/rtl/mbr_back.sv]
module mbr_back (
  input logic        clk,
  input logic        rst,
  mbr_cmd_if.sink    cmd,
  mbr_out_if.source  rsp
);

  localparam int unsigned AW   = mbr_pkg::BUF_AW;
  localparam int unsigned CW   = mbr_pkg::CNT_W;
  localparam int unsigned RW   = mbr_pkg::REM_W;
  localparam int unsigned VW   = mbr_pkg::VALUE_W;

  logic [7:0]                mem [mbr_pkg::BUF_BYTES];
  logic [7:0]                rd_data;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;

  mbr_pkg::back_state_t      state, state_next;
  logic [AW-1:0]             head, head_next;
  logic [AW-1:0]             tail, tail_next;
  logic [CW-1:0]             count, count_next;
  logic [2:0]                bitpos, bitpos_next;
  logic [RW-1:0]             rem, rem_next;
  logic [VW-1:0]             acc, acc_next;

  logic                      out_valid;
  logic [VW-1:0]             out_value;
  mbr_pkg::status_t          out_status;
  logic [7:0]                out_left;

  logic                      load_out;
  logic [VW-1:0]             res_value;
  mbr_pkg::status_t          res_status;
  logic [7:0]                res_left;

  logic                      free;
  logic                      pop;
  logic                      under;
  logic [mbr_pkg::UNREAD_W-1:0] unread_now;
  logic [3:0]                avail;
  logic [3:0]                take;
  logic [7:0]                aligned;
  logic [7:0]                chunk;
  logic                      byte_done;

  assign free       = !out_valid || rsp.ready;
  assign cmd.ready  = free && (state == mbr_pkg::BK_IDLE);
  assign pop        = cmd.valid && cmd.ready;
  assign unread_now = mbr_pkg::unread(count, bitpos);
  assign under      = cmd.cmd.n > unread_now;

  assign avail     = 4'd8 - {1'b0, bitpos};
  assign take      = (rem < RW'(avail)) ? rem[3:0] : avail;
  assign aligned   = rd_data << bitpos;
  assign chunk     = aligned >> (4'd8 - take);
  assign byte_done = (take == avail);

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.status    = out_status;
  assign rsp.bits_left = out_left;

  always_comb begin
    state_next = state;
    case (state)
      mbr_pkg::BK_IDLE: begin
        if (pop && cmd.cmd.kind == mbr_pkg::CMD_READ && !under) begin
          state_next = mbr_pkg::BK_TAKE;
        end
      end
      mbr_pkg::BK_TAKE: begin
        if (rem == RW'(take)) begin
          state_next = mbr_pkg::BK_IDLE;
        end
      end
      default: state_next = mbr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    bitpos_next = bitpos;
    rem_next    = rem;
    acc_next    = acc;
    rd_addr     = head;
    wr_en       = 1'b0;
    load_out    = 1'b0;
    res_value   = '0;
    res_status  = mbr_pkg::ST_OK;
    res_left    = mbr_pkg::sat8(unread_now);
    case (state)
      mbr_pkg::BK_IDLE: begin
        if (pop) begin
          case (cmd.cmd.kind)
            mbr_pkg::CMD_PUSH: begin
              load_out = 1'b1;
              if (count == CW'(mbr_pkg::BUF_BYTES)) begin
                res_status = mbr_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                tail_next  = mbr_pkg::next_idx(tail);
                count_next = count + CW'(1);
                res_left   = mbr_pkg::sat8(mbr_pkg::unread(count_next, bitpos));
              end
            end
            mbr_pkg::CMD_READ: begin
              if (under) begin
                load_out   = 1'b1;
                res_status = mbr_pkg::ST_UNDERFLOW;
              end else begin
                rem_next = RW'(cmd.cmd.n);
                acc_next = '0;
              end
            end
            default: begin
              load_out   = 1'b1;
              res_status = mbr_pkg::ST_BADCOUNT;
            end
          endcase
        end
      end
      mbr_pkg::BK_TAKE: begin
        acc_next = (acc << take) | VW'(chunk);
        rem_next = rem - RW'(take);
        if (byte_done) begin
          bitpos_next = 3'd0;
          head_next   = mbr_pkg::next_idx(head);
          count_next  = count - CW'(1);
        end else begin
          bitpos_next = bitpos + take[2:0];
        end
        rd_addr = head_next;
        if (rem_next == '0) begin
          load_out  = 1'b1;
          res_value = acc_next;
          res_left  = mbr_pkg::sat8(mbr_pkg::unread(count_next, bitpos_next));
        end
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= cmd.cmd.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbr_pkg::BK_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      bitpos    <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      bitpos <= bitpos_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    acc <= acc_next;
    if (load_out) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_left   <= res_left;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mbr_pkg::BUF_BYTES))
    else $error("byte count above capacity");

  a_pos_needs_byte: assert property (@(posedge clk) disable iff (rst)
    (bitpos != 3'd0) |-> (count != '0))
    else $error("bit position set with empty store");

  a_take_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mbr_pkg::BK_TAKE) |-> !out_valid)
    else $error("result pending during read");

  a_take_rem: assert property (@(posedge clk) disable iff (rst)
    (state == mbr_pkg::BK_TAKE) |-> (rem != '0))
    else $error("read running with no bits left to take");

endmodule

[hw/rtl/msb_first_bit_reader_top.sv]
// Items pass a front register that classifies them and a two-entry command queue; the back
// end registers the result of a push, bad count, underflow or full item on accept. A read
// item holds the back end in its take state, one byte of the store read per cycle, until
// its last bit is taken. Throughput: one push or error item per cycle while the result register is free.
// Reset (rst, synchronous) empties the store, clears the bit position and both queues;
// store contents stay undefined until pushed.
module msb_first_bit_reader_top (
  input logic        clk,
  input logic        rst,
  mbr_in_if.sink     req,
  mbr_out_if.source  rsp
);

  mbr_cmd_if front_cmd ();
  mbr_cmd_if back_cmd ();

  mbr_front u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (front_cmd)
  );

  mbr_cmdq u_cmdq (
    .clk (clk),
    .rst (rst),
    .enq (front_cmd),
    .deq (back_cmd)
  );

  mbr_back u_back (
    .clk (clk),
    .rst (rst),
    .cmd (back_cmd),
    .rsp (rsp)
  );

endmodule

[bench/mbr_tb_pkg.sv]
`timescale 1ns / 100ps

package mbr_tb_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } reader_op_t;

endpackage

[bench/msb_reader_checker.sv]
`timescale 1ns / 100ps

module msb_reader_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  logic              op,
  input  logic [7:0]        byte_in,
  input  logic [5:0]        n_bits,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  logic [31:0]       value,
  input  mbr_pkg::status_t  status,
  input  logic [7:0]        bits_left,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [31:0]      value;
    mbr_pkg::status_t status;
    logic [7:0]       bits_left;
  } reader_result_t;

  logic [7:0]     stored_bytes [mbr_pkg::BUF_BYTES];
  int unsigned    head;
  int unsigned    tail;
  int unsigned    fill;
  int unsigned    bit_pos;
  reader_result_t expected_results [$];

  function automatic reader_result_t bitread_outcome(input logic item_op,
                                                     input logic [7:0] data,
                                                     input logic [5:0] count);
    reader_result_t r;
    int unsigned    unread;
    r.value  = '0;
    r.status = mbr_pkg::ST_OK;
    unread   = fill * 8 - bit_pos;
    if (item_op == mbr_tb_pkg::OP_PUSH) begin
      if (fill >= mbr_pkg::BUF_BYTES) begin
        r.status = mbr_pkg::ST_FULL;
      end else begin
        stored_bytes[tail] = data;
        tail = (tail + 1) % mbr_pkg::BUF_BYTES;
        fill++;
      end
    end else if (count == 0 || count > mbr_pkg::MAX_READ_BITS) begin
      r.status = mbr_pkg::ST_BADCOUNT;
    end else if (count > unread) begin
      r.status = mbr_pkg::ST_UNDERFLOW;
    end else begin
      for (int i = 0; i < count; i++) begin
        r.value = {r.value[30:0], stored_bytes[head][7 - bit_pos]};
        if (bit_pos == 7) begin
          bit_pos = 0;
          head = (head + 1) % mbr_pkg::BUF_BYTES;
          fill--;
        end else begin
          bit_pos++;
        end
      end
    end
    unread = fill * 8 - bit_pos;
    r.bits_left = (unread > 255) ? 8'hFF : 8'(unread);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    reader_result_t want;
    if (rst) begin
      head = 0;
      tail = 0;
      fill = 0;
      bit_pos = 0;
      expected_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: value %h status %0d bits_left %0d",
                                    value, status, bits_left));
        end else begin
          want = expected_results.pop_front();
          if (value !== want.value) begin
            report_mismatch($sformatf("value %h, want %h", value, want.value));
          end
          if (status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          end
          if (bits_left !== want.bits_left) begin
            report_mismatch($sformatf("bits_left %0d, want %0d", bits_left, want.bits_left));
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_results.push_back(bitread_outcome(op, byte_in, n_bits));
      end
    end
    pending <= expected_results.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  logic clk = 1'b0;
  logic rst;
  int   src_idle;
  int   sink_idle;
  int   items_sent;
  int   pending;
  int   mismatches;

  mbr_in_if  req_if ();
  mbr_out_if rsp_if ();

  msb_first_bit_reader_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  msb_reader_checker reader_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .op         (req_if.op),
    .byte_in    (req_if.byte_in),
    .n_bits     (req_if.n_bits),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .value      (rsp_if.value),
    .status     (rsp_if.status),
    .bits_left  (rsp_if.bits_left),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_idle);
  end

  task automatic send_item(input logic item_op, input logic [7:0] data,
                           input logic [5:0] count);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= item_op;
    req_if.byte_in <= data;
    req_if.n_bits  <= count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic random_segment();
    int pick;
    int len;
    int r;
    logic [5:0] count;
    pick = $urandom_range(99);
    if (pick < 2) begin
      wait_drained();
    end else if (pick < 42) begin
      len = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 8);
      repeat (len) send_item(mbr_tb_pkg::OP_PUSH, 8'($urandom_range(255)),
                             6'($urandom_range(63)));
    end else if (pick < 87) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 45) begin
          count = 6'($urandom_range(1, 8));
        end else if (r < 80) begin
          count = 6'($urandom_range(9, 24));
        end else begin
          count = 6'($urandom_range(25, 32));
        end
        send_item(mbr_tb_pkg::OP_READ, 8'($urandom_range(255)), count);
      end
    end else begin
      send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 6'($urandom_range(63)));
    end
  endtask

  initial begin
    int phase_end;
    req_if.valid   = 1'b0;
    req_if.op      = mbr_tb_pkg::OP_PUSH;
    req_if.byte_in = 8'h00;
    req_if.n_bits  = 6'd0;
    rsp_if.ready   = 1'b0;
    rst            = 1'b1;
    src_idle       = 32;
    sink_idle      = 78;
    items_sent     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty queue, bad counts, fill to full, then wide and unaligned reads
    send_item(mbr_tb_pkg::OP_READ, 8'h00, 6'd1);
    send_item(mbr_tb_pkg::OP_READ, 8'hFF, 6'd0);
    send_item(mbr_tb_pkg::OP_READ, 8'h00, 6'd33);
    send_item(mbr_tb_pkg::OP_READ, 8'hFF, 6'd63);
    send_item(mbr_tb_pkg::OP_PUSH, 8'hFF, 6'd63);
    send_item(mbr_tb_pkg::OP_PUSH, 8'h00, 6'd0);
    repeat (14) send_item(mbr_tb_pkg::OP_PUSH, 8'($urandom_range(255)), 6'd32);
    send_item(mbr_tb_pkg::OP_PUSH, 8'hA5, 6'd0);
    send_item(mbr_tb_pkg::OP_READ, 8'h00, 6'd32);
    send_item(mbr_tb_pkg::OP_READ, 8'hFF, 6'd3);
    send_item(mbr_tb_pkg::OP_READ, 8'h00, 6'd32);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle  = 32;
          sink_idle = 78;
        end
        1: begin
          src_idle  = 78;
          sink_idle = 32;
        end
        default: begin
          src_idle  = 0;
          sink_idle = 0;
        end
      endcase
      phase_end = items_sent + 630;
      while (items_sent < phase_end) random_segment();
      wait_drained();
    end

    repeat (12) @(negedge clk);
    if (mismatches == 0) begin
      $display("** msb_first_bit_reader_top: PASSED **");
    end else begin
      $display("** msb_first_bit_reader_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** msb_first_bit_reader_top: FAILED **");
    $finish;
  end

endmodule
